@@ hw/rtl/ise_pkg.sv @@
// Shared types and constants of the interpolation seek engine.
// Holds the microcode format, the microprogram table, status codes and
// register addresses. Depends on nothing.
`default_nettype none

package ise_pkg;

  // Result status codes.
  localparam logic [2:0] ST_PROBE        = 3'd0;
  localparam logic [2:0] ST_DONE         = 3'd1;
  localparam logic [2:0] ST_NO_GRANULE   = 3'd2;
  localparam logic [2:0] ST_INCONSISTENT = 3'd3;
  localparam logic [2:0] ST_ZERO_SPAN    = 3'd4;

  // Request kinds.
  localparam logic KIND_START = 1'b0;

  // Configuration port: 64-bit registers at 8-byte spacing.
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 64;
  localparam logic [CFG_ADDR_BITS-1:0] ADDR_STREAM_SIZE   = 5'd0;
  localparam logic [CFG_ADDR_BITS-1:0] ADDR_END_GRANULE   = 5'd8;
  localparam logic [CFG_ADDR_BITS-1:0] ADDR_MARGIN_BEFORE = 5'd16;
  localparam logic [CFG_ADDR_BITS-1:0] ADDR_MARGIN_AFTER  = 5'd24;

  localparam int MARGIN_BITS = 32;
  localparam logic [MARGIN_BITS-1:0] MARGIN_BEFORE_RESET = MARGIN_BITS'(44100 / 3);
  localparam logic [MARGIN_BITS-1:0] MARGIN_AFTER_RESET  = MARGIN_BITS'(44100 / 10);

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_TAKE,
    OP_DIFF,
    OP_SET_HIGH,
    OP_SET_LOW,
    OP_LOAD,
    OP_SPAN,
    OP_MUL_INIT,
    OP_MUL,
    OP_DIV_INIT,
    OP_DIV,
    OP_OFFSET,
    OP_EMIT
  } op_t;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ITEM,
    C_START,
    C_IDLE,
    C_NEG_FOUND,
    C_ABOVE,
    C_BELOW,
    C_GT_HIGH,
    C_EQ_HIGH,
    C_LT_LOW,
    C_EQ_LOW,
    C_ZERO_SPAN,
    C_CNT_NZ,
    C_QBIG
  } cond_t;

  localparam int STEP_BITS = 5;
  typedef logic [STEP_BITS-1:0] step_t;

  typedef struct packed {
    op_t        op;
    cond_t      cond;
    step_t      target;
    logic [2:0] status;
  } ctl_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic item_valid;
    logic out_free;
    logic is_start;
    logic searching;
    logic found_neg;
    logic above;
    logic below;
    logic gt_high;
    logic eq_high;
    logic lt_low;
    logic eq_low;
    logic zero_span;
    logic cnt_nz;
    logic qbig;
  } flags_t;

  // Microprogram addresses.
  localparam step_t STEP_IDLE        = 5'd0;
  localparam step_t STEP_KIND        = 5'd1;
  localparam step_t STEP_ACTIVE      = 5'd2;
  localparam step_t STEP_NEG         = 5'd3;
  localparam step_t STEP_DIFF        = 5'd4;
  localparam step_t STEP_ABOVE       = 5'd5;
  localparam step_t STEP_BELOW       = 5'd6;
  localparam step_t STEP_INSIDE      = 5'd7;
  localparam step_t STEP_HI_CHK      = 5'd8;
  localparam step_t STEP_HI_EQ       = 5'd9;
  localparam step_t STEP_HI_SET      = 5'd10;
  localparam step_t STEP_LO_CHK      = 5'd11;
  localparam step_t STEP_LO_EQ       = 5'd12;
  localparam step_t STEP_LO_SET      = 5'd13;
  localparam step_t STEP_START       = 5'd14;
  localparam step_t STEP_PROBE       = 5'd15;
  localparam step_t STEP_SPAN        = 5'd16;
  localparam step_t STEP_MUL_INIT    = 5'd17;
  localparam step_t STEP_MUL         = 5'd18;
  localparam step_t STEP_DIV_INIT    = 5'd19;
  localparam step_t STEP_DIV         = 5'd20;
  localparam step_t STEP_OFFSET      = 5'd21;
  localparam step_t STEP_EMIT_PROBE  = 5'd22;
  localparam step_t STEP_EMIT_DONE   = 5'd23;
  localparam step_t STEP_EMIT_NOGRAN = 5'd24;
  localparam step_t STEP_EMIT_INCONS = 5'd25;
  localparam step_t STEP_EMIT_ZERO   = 5'd26;

  function automatic ctl_t uw(input op_t op, input cond_t cond, input step_t target,
                              input logic [2:0] status);
    ctl_t c;
    c.op     = op;
    c.cond   = cond;
    c.target = target;
    c.status = status;
    return c;
  endfunction

  // The control store. A step jumps to its target when its condition
  // holds and otherwise falls through to the next address.
  function automatic ctl_t ucode(input step_t step);
    ctl_t c;
    case (step)
      STEP_IDLE:        c = uw(OP_TAKE,     C_NO_ITEM,   STEP_IDLE,        ST_PROBE);
      STEP_KIND:        c = uw(OP_NOP,      C_START,     STEP_START,       ST_PROBE);
      STEP_ACTIVE:      c = uw(OP_NOP,      C_IDLE,      STEP_IDLE,        ST_PROBE);
      STEP_NEG:         c = uw(OP_NOP,      C_NEG_FOUND, STEP_EMIT_NOGRAN, ST_PROBE);
      STEP_DIFF:        c = uw(OP_DIFF,     C_NEVER,     STEP_IDLE,        ST_PROBE);
      STEP_ABOVE:       c = uw(OP_NOP,      C_ABOVE,     STEP_HI_CHK,      ST_PROBE);
      STEP_BELOW:       c = uw(OP_NOP,      C_BELOW,     STEP_LO_CHK,      ST_PROBE);
      STEP_INSIDE:      c = uw(OP_NOP,      C_ALWAYS,    STEP_EMIT_DONE,   ST_PROBE);
      STEP_HI_CHK:      c = uw(OP_NOP,      C_GT_HIGH,   STEP_EMIT_INCONS, ST_PROBE);
      STEP_HI_EQ:       c = uw(OP_NOP,      C_EQ_HIGH,   STEP_EMIT_DONE,   ST_PROBE);
      STEP_HI_SET:      c = uw(OP_SET_HIGH, C_ALWAYS,    STEP_PROBE,       ST_PROBE);
      STEP_LO_CHK:      c = uw(OP_NOP,      C_LT_LOW,    STEP_EMIT_INCONS, ST_PROBE);
      STEP_LO_EQ:       c = uw(OP_NOP,      C_EQ_LOW,    STEP_EMIT_DONE,   ST_PROBE);
      STEP_LO_SET:      c = uw(OP_SET_LOW,  C_ALWAYS,    STEP_PROBE,       ST_PROBE);
      STEP_START:       c = uw(OP_LOAD,     C_NEVER,     STEP_IDLE,        ST_PROBE);
      STEP_PROBE:       c = uw(OP_NOP,      C_ZERO_SPAN, STEP_EMIT_ZERO,   ST_PROBE);
      STEP_SPAN:        c = uw(OP_SPAN,     C_NEVER,     STEP_IDLE,        ST_PROBE);
      STEP_MUL_INIT:    c = uw(OP_MUL_INIT, C_NEVER,     STEP_IDLE,        ST_PROBE);
      STEP_MUL:         c = uw(OP_MUL,      C_CNT_NZ,    STEP_MUL,         ST_PROBE);
      STEP_DIV_INIT:    c = uw(OP_DIV_INIT, C_QBIG,      STEP_OFFSET,      ST_PROBE);
      STEP_DIV:         c = uw(OP_DIV,      C_CNT_NZ,    STEP_DIV,         ST_PROBE);
      STEP_OFFSET:      c = uw(OP_OFFSET,   C_NEVER,     STEP_IDLE,        ST_PROBE);
      STEP_EMIT_PROBE:  c = uw(OP_EMIT,     C_ALWAYS,    STEP_IDLE,        ST_PROBE);
      STEP_EMIT_DONE:   c = uw(OP_EMIT,     C_ALWAYS,    STEP_IDLE,        ST_DONE);
      STEP_EMIT_NOGRAN: c = uw(OP_EMIT,     C_ALWAYS,    STEP_IDLE,        ST_NO_GRANULE);
      STEP_EMIT_INCONS: c = uw(OP_EMIT,     C_ALWAYS,    STEP_IDLE,        ST_INCONSISTENT);
      STEP_EMIT_ZERO:   c = uw(OP_EMIT,     C_ALWAYS,    STEP_IDLE,        ST_ZERO_SPAN);
      default:          c = uw(OP_NOP,      C_ALWAYS,    STEP_IDLE,        ST_PROBE);
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ise_in_if.sv @@
// Request channel of the interpolation seek engine: valid/ready plus the
// fields of one request. Stands alone; widths come from its parameters.
`default_nettype none

interface ise_in_if #(
  parameter int OFFSET_BITS  = 48,
  parameter int GRANULE_BITS = 63
);
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [GRANULE_BITS-2:0]        target_granule;
  logic signed [GRANULE_BITS-1:0] found_granule;
  logic [OFFSET_BITS-1:0]         page_start;

  modport source (output valid, kind, target_granule, found_granule, page_start,
                  input ready);
  modport sink (input valid, kind, target_granule, found_granule, page_start,
                output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ise_out_if.sv @@
// Result channel of the interpolation seek engine: valid/ready plus the
// seek offset and status. Stands alone; the offset width is a parameter.
`default_nettype none

interface ise_out_if #(
  parameter int OFFSET_BITS = 48
);
  logic                   valid;
  logic                   ready;
  logic [OFFSET_BITS-1:0] seek_offset;
  logic [2:0]             status;

  modport source (output valid, seek_offset, status, input ready);
  modport sink (input valid, seek_offset, status, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ise_cfg.sv @@
// APB-style configuration registers of the seek engine.
// Depends on ise_pkg for addresses and reset values of the margins.
`default_nettype none

module ise_cfg #(
  parameter int OW = 48,
  parameter int TW = 62
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ise_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [ise_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic      [ise_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                                   pready,
  output logic      [OW-1:0]                     stream_size,
  output logic      [TW-1:0]                     end_granule,
  output logic      [ise_pkg::MARGIN_BITS-1:0]   margin_before,
  output logic      [ise_pkg::MARGIN_BITS-1:0]   margin_after
);
  import ise_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_size   <= '0;
      end_granule   <= '0;
      margin_before <= MARGIN_BEFORE_RESET;
      margin_after  <= MARGIN_AFTER_RESET;
    end else if (wr) begin
      case (paddr)
        ADDR_STREAM_SIZE:   stream_size   <= pwdata[OW-1:0];
        ADDR_END_GRANULE:   end_granule   <= pwdata[TW-1:0];
        ADDR_MARGIN_BEFORE: margin_before <= pwdata[MARGIN_BITS-1:0];
        ADDR_MARGIN_AFTER:  margin_after  <= pwdata[MARGIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ADDR_STREAM_SIZE:   prdata = CFG_DATA_BITS'(stream_size);
      ADDR_END_GRANULE:   prdata = CFG_DATA_BITS'(end_granule);
      ADDR_MARGIN_BEFORE: prdata = CFG_DATA_BITS'(margin_before);
      ADDR_MARGIN_AFTER:  prdata = CFG_DATA_BITS'(margin_after);
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/ise_sequencer.sv @@
// Microprogram sequencer: step counter, control store fetch and branch.
// Depends on ise_pkg for the control word, flags and the program table.
`default_nettype none

module ise_sequencer (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ise_pkg::flags_t flags,
  output ise_pkg::ctl_t        ctl
);
  import ise_pkg::*;

  step_t pc;
  step_t pc_next;
  logic  taken;
  logic  hold;

  assign ctl = ucode(pc);

  always_comb begin
    case (ctl.cond)
      C_NEVER:     taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_NO_ITEM:   taken = !flags.item_valid;
      C_START:     taken = flags.is_start;
      C_IDLE:      taken = !flags.searching;
      C_NEG_FOUND: taken = flags.found_neg;
      C_ABOVE:     taken = flags.above;
      C_BELOW:     taken = flags.below;
      C_GT_HIGH:   taken = flags.gt_high;
      C_EQ_HIGH:   taken = flags.eq_high;
      C_LT_LOW:    taken = flags.lt_low;
      C_EQ_LOW:    taken = flags.eq_low;
      C_ZERO_SPAN: taken = flags.zero_span;
      C_CNT_NZ:    taken = flags.cnt_nz;
      C_QBIG:      taken = flags.qbig;
      default:     taken = 1'b0;
    endcase
  end

  // An emit step waits until the output register can take the result.
  assign hold = (ctl.op == OP_EMIT) && !flags.out_free;

  always_comb begin
    if (hold) begin
      pc_next = pc;
    end else if (taken) begin
      pc_next = ctl.target;
    end else begin
      pc_next = pc + STEP_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ise_datapath.sv @@
// Datapath of the seek engine: search bounds, request latch, radix-4
// shift-add multiplier, restoring divider and the output register.
// Depends on ise_pkg and the ise_in_if / ise_out_if channel interfaces.
`default_nettype none

module ise_datapath #(
  parameter int OW = 48,
  parameter int GW = 63
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire ise_pkg::ctl_t                   ctl,
  output ise_pkg::flags_t                      flags,
  ise_in_if.sink                               item,
  ise_out_if.source                            result,
  input  wire logic [OW-1:0]                   stream_size,
  input  wire logic [GW-2:0]                   end_granule,
  input  wire logic [ise_pkg::MARGIN_BITS-1:0] margin_before,
  input  wire logic [ise_pkg::MARGIN_BITS-1:0] margin_after
);
  import ise_pkg::*;

  localparam int TW   = GW - 1;
  localparam int PW   = GW + OW;
  localparam int DW   = OW + (OW % 2);
  localparam int ND   = DW / 2;
  localparam int CW   = (GW + 1 > MARGIN_BITS) ? GW + 1 : MARGIN_BITS;
  localparam int CNTW = $clog2(OW);

  // Latched request.
  logic                 kind;
  logic [TW-1:0]        target;
  logic signed [GW-1:0] found;
  logic [OW-1:0]        page;

  // Search state.
  logic [OW-1:0]        low_offset;
  logic [OW-1:0]        high_offset;
  logic signed [GW-1:0] low_granule;
  logic signed [GW-1:0] high_granule;
  logic signed [GW-1:0] sought_granule;
  logic                 searching;

  // Work registers.
  logic [GW:0]          ahead;
  logic [GW:0]          behind;
  logic [GW-1:0]        rel;
  logic [GW+1:0]        rel3;
  logic [GW-1:0]        dgran;
  logic [DW-1:0]        doff;
  logic                 nrel;
  logic                 noff;
  logic                 ngran;
  logic [PW-1:0]        acc;
  logic [CNTW-1:0]      cnt;
  logic                 qbig;
  logic [OW:0]          off_sum;

  // Output register.
  logic                 out_valid;
  logic [OW-1:0]        seek_offset;
  logic [2:0]           status;

  logic          out_free;
  logic          emit_go;
  logic [GW:0]   rel_ab, rel_ba, gr_ab, gr_ba;
  logic [OW:0]   off_ab, off_ba;
  logic [PW-1:0] addend;
  logic [GW:0]   div_sh;
  logic          div_ge;
  logic [GW-1:0] div_rem;
  logic          qbig_now;
  logic          neg;
  logic [OW-1:0] quot;
  logic [OW:0]   off_sub, off_add;
  logic [OW-1:0] clamped;

  assign out_free = !out_valid || result.ready;
  assign emit_go  = (ctl.op == OP_EMIT) && out_free;

  assign item.ready         = (ctl.op == OP_TAKE);
  assign result.valid       = out_valid;
  assign result.seek_offset = seek_offset;
  assign result.status      = status;

  // Signed differences, both directions, so the magnitude needs no negation.
  assign rel_ab = {sought_granule[GW-1], sought_granule} - {low_granule[GW-1], low_granule};
  assign rel_ba = {low_granule[GW-1], low_granule} - {sought_granule[GW-1], sought_granule};
  assign gr_ab  = {high_granule[GW-1], high_granule} - {low_granule[GW-1], low_granule};
  assign gr_ba  = {low_granule[GW-1], low_granule} - {high_granule[GW-1], high_granule};
  assign off_ab = {1'b0, high_offset} - {1'b0, low_offset};
  assign off_ba = {1'b0, low_offset} - {1'b0, high_offset};

  always_comb begin
    case (doff[DW-1:DW-2])
      2'd0:    addend = '0;
      2'd1:    addend = PW'(rel);
      2'd2:    addend = PW'({rel, 1'b0});
      2'd3:    addend = PW'(rel3);
      default: addend = '0;
    endcase
  end

  // One restoring division step: the partial remainder sits in the upper
  // part of acc and quotient bits shift in at the bottom.
  assign div_sh  = {acc[PW-1:OW], acc[OW-1]};
  assign div_ge  = div_sh >= {1'b0, dgran};
  assign div_rem = div_ge ? GW'(div_sh - {1'b0, dgran}) : div_sh[GW-1:0];

  assign qbig_now = acc[PW-1:OW] >= dgran;

  assign quot    = acc[OW-1:0];
  assign neg     = nrel ^ noff ^ ngran;
  assign off_sub = {1'b0, low_offset} - {1'b0, quot};
  assign off_add = {1'b0, low_offset} + {1'b0, quot};
  assign clamped = (off_sum > {1'b0, stream_size}) ? stream_size : off_sum[OW-1:0];

  always_comb begin
    flags.item_valid = item.valid;
    flags.out_free   = out_free;
    flags.is_start   = (kind == KIND_START);
    flags.searching  = searching;
    flags.found_neg  = found[GW-1];
    flags.above      = !ahead[GW] && (CW'(ahead[GW-1:0]) > CW'(margin_after));
    flags.below      = !behind[GW] && (CW'(behind[GW-1:0]) > CW'(margin_before));
    flags.gt_high    = found > high_granule;
    flags.eq_high    = found == high_granule;
    flags.lt_low     = found < low_granule;
    flags.eq_low     = found == low_granule;
    flags.zero_span  = high_granule == low_granule;
    flags.cnt_nz     = cnt != '0;
    flags.qbig       = qbig_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      searching      <= 1'b0;
      low_offset     <= '0;
      high_offset    <= '0;
      low_granule    <= '0;
      high_granule   <= '0;
      sought_granule <= '0;
    end else begin
      case (ctl.op)
        OP_LOAD: begin
          low_offset     <= '0;
          high_offset    <= stream_size;
          low_granule    <= '0;
          high_granule   <= $signed({1'b0, end_granule});
          sought_granule <= $signed({1'b0, target});
        end
        OP_SET_HIGH: begin
          high_granule <= found;
          high_offset  <= page;
        end
        OP_SET_LOW: begin
          low_granule <= found;
          low_offset  <= page;
        end
        OP_EMIT: begin
          if (out_free) begin
            searching <= (ctl.status == ST_PROBE);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_TAKE: begin
        if (item.valid) begin
          kind   <= item.kind;
          target <= item.target_granule;
          found  <= item.found_granule;
          page   <= item.page_start;
        end
      end
      OP_DIFF: begin
        ahead  <= {found[GW-1], found} - {sought_granule[GW-1], sought_granule};
        behind <= {sought_granule[GW-1], sought_granule} - {found[GW-1], found};
      end
      OP_SPAN: begin
        nrel  <= rel_ab[GW];
        rel   <= rel_ab[GW] ? rel_ba[GW-1:0] : rel_ab[GW-1:0];
        ngran <= gr_ab[GW];
        dgran <= gr_ab[GW] ? gr_ba[GW-1:0] : gr_ab[GW-1:0];
        noff  <= off_ab[OW];
        doff  <= DW'(off_ab[OW] ? off_ba[OW-1:0] : off_ab[OW-1:0]);
      end
      OP_MUL_INIT: begin
        rel3 <= (GW + 2)'(rel) + {1'b0, rel, 1'b0};
        acc  <= '0;
        cnt  <= CNTW'(ND - 1);
      end
      OP_MUL: begin
        acc  <= {acc[PW-3:0], 2'b00} + addend;
        doff <= {doff[DW-3:0], 2'b00};
        cnt  <= cnt - CNTW'(1);
      end
      OP_DIV_INIT: begin
        qbig <= qbig_now;
        cnt  <= CNTW'(OW - 1);
      end
      OP_DIV: begin
        acc <= {div_rem, acc[OW-2:0], div_ge};
        cnt <= cnt - CNTW'(1);
      end
      OP_OFFSET: begin
        // A quotient past the offset range drives the result to a bound.
        if (qbig) begin
          off_sum <= neg ? '0 : '1;
        end else if (neg) begin
          off_sum <= off_sub[OW] ? '0 : off_sub;
        end else begin
          off_sum <= off_add;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      status <= ctl.status;
      case (ctl.status)
        ST_PROBE: seek_offset <= clamped;
        ST_DONE:  seek_offset <= page;
        default:  seek_offset <= '0;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/interpolation_seek_engine.sv @@
// Interpolation seek engine, top level.
// Instantiates ise_cfg, ise_sequencer and ise_datapath; uses ise_pkg and
// the ise_in_if / ise_out_if channel interfaces.
//
// Usage: software writes stream_size, end_granule and the two margins over
// the APB port, then sends a start request carrying the target granule.
// Each result with status probe names a byte offset; the host reads there
// and sends a probe-result request with the granule found and the page
// start. This repeats until a result with any other status ends the search.
// Probe-result requests that arrive while no search runs give no result.
// A request that leads to a new probe runs the radix-4 shift-add multiply
// loop and the restoring divider, which retires one quotient bit per step.
// Requests that end the search skip both loops. One request is worked on
// at a time.
// Reset clears the bounds, sets the margins to 14700 and 4410 and leaves
// the block idle and ready for a request at once.
// A stalled receiver holds the result in the output register; the next
// request is still taken, and its result waits until the register frees.
`default_nettype none

module interpolation_seek_engine #(
  parameter int OFFSET_BITS  = 48,
  parameter int GRANULE_BITS = 63
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ise_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [ise_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic      [ise_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                                   pready,
  ise_in_if.sink                                 item,
  ise_out_if.source                              result
);
  import ise_pkg::*;

  ctl_t                    ctl;
  flags_t                  flags;
  logic [OFFSET_BITS-1:0]  stream_size;
  logic [GRANULE_BITS-2:0] end_granule;
  logic [MARGIN_BITS-1:0]  margin_before;
  logic [MARGIN_BITS-1:0]  margin_after;

  ise_cfg #(
    .OW (OFFSET_BITS),
    .TW (GRANULE_BITS - 1)
  ) u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .stream_size   (stream_size),
    .end_granule   (end_granule),
    .margin_before (margin_before),
    .margin_after  (margin_after)
  );

  ise_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl)
  );

  ise_datapath #(
    .OW (OFFSET_BITS),
    .GW (GRANULE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .flags         (flags),
    .item          (item),
    .result        (result),
    .stream_size   (stream_size),
    .end_granule   (end_granule),
    .margin_before (margin_before),
    .margin_after  (margin_after)
  );

endmodule

`default_nettype wire

@@ hw/rtl/ise_checker.sv @@
// Port-level checks for the interpolation seek engine, bound to the top.
// Depends on ise_pkg for the status codes.
`default_nettype none

module ise_checker #(
  parameter int OW = 48
) (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire logic [OW-1:0] seek_offset,
  input wire logic [2:0]    status
);
  import ise_pkg::*;

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(seek_offset) && $stable(status))
    else $error("result changed while stalled");

  // Error results carry no offset.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NO_GRANULE || status == ST_INCONSISTENT ||
                  status == ST_ZERO_SPAN) |-> seek_offset == '0)
    else $error("error result with nonzero offset");

  // A request is worked on alone, so no request is taken right after one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken in back-to-back cycles");

  // A new result comes from an emit step, where no request is taken.
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while the block was waiting for a request");

endmodule

bind interpolation_seek_engine ise_checker #(
  .OW (OFFSET_BITS)
) u_ise_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (item.valid),
  .in_ready    (item.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .seek_offset (result.seek_offset),
  .status      (result.status)
);

`default_nettype wire
